### rtl/core/pdbal_pkg.sv
// Shared types and constants for the PD balance motor drive block.
// No dependencies; imported by every module in rtl/core.
package pdbal_pkg;

   // Drive direction codes on the result channel
   localparam logic [1:0] DIR_FORWARD  = 2'd0;
   localparam logic [1:0] DIR_BACKWARD = 2'd1;
   localparam logic [1:0] DIR_STOPPED  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_TARGET_ANGLE = 3'd0;
   localparam logic [2:0] CSR_PROP_GAIN    = 3'd1;
   localparam logic [2:0] CSR_DERIV_GAIN   = 3'd2;
   localparam logic [2:0] CSR_DEAD_BAND    = 3'd3;
   localparam logic [2:0] CSR_DUTY_FLOOR   = 3'd4;
   localparam logic [2:0] CSR_DUTY_CEILING = 3'd5;
   localparam logic [2:0] CSR_RIGHT_SCALE  = 3'd6;

   // Reset values
   localparam logic [15:0] RST_PROP_GAIN    = 16'd5120;
   localparam logic [15:0] RST_DERIV_GAIN   = 16'd4096;
   localparam logic [7:0]  RST_DUTY_FLOOR   = 8'd55;
   localparam logic [7:0]  RST_DUTY_CEILING = 8'd150;
   localparam logic [15:0] RST_RIGHT_SCALE  = 16'd60621;
   localparam logic [15:0] RST_DRIVE_LEVEL  = 16'd14080;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MULD,
      ST_SUM,
      ST_LEVEL,
      ST_SCALE,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // take the item, form error
      logic diff;      // error change, kp product, direction
      logic muld;      // kd product, park kp product
      logic sum;       // add the two products
      logic level;     // accumulate and clamp drive level
      logic scale;     // right duty product
      logic load_out;  // fill the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

### rtl/core/pdbal_ctrl.sv
// Sequencer for the PD balance motor drive: one item walks through the steps.
// Depends on pdbal_pkg.
module pdbal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pdbal_pkg::status_type  status,
   output pdbal_pkg::cmd_type     cmd
);
   import pdbal_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MULD;
         end
         ST_MULD: begin
            cmd.muld = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // wait until the result register is free
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/pdbal_dp.sv
// Datapath of the PD balance motor drive: config registers, shared multiplier,
// accumulator, clamp and result register. Depends on pdbal_pkg.
module pdbal_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pdbal_pkg::cmd_type     cmd,
   output pdbal_pkg::status_type  status,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic signed [15:0]     req_tilt_angle,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_drive_direction,
   output logic [7:0]             rsp_left_duty,
   output logic [7:0]             rsp_right_duty,
   output logic [15:0]            rsp_drive_level_out,
   output logic signed [16:0]     rsp_angle_error
);
   import pdbal_pkg::*;

   // configuration
   logic signed [15:0] target_ff;
   logic [15:0]        kp_ff;
   logic [15:0]        kd_ff;
   logic [14:0]        dead_band_ff;
   logic [7:0]         floor_ff;
   logic [7:0]         ceiling_ff;
   logic [15:0]        scale_ff;

   // state
   logic [15:0]        level_ff, level_in;
   logic signed [17:0] prev_ff;

   // working registers
   logic signed [15:0] angle_ff;
   logic signed [16:0] err_ff, err_in;
   logic signed [17:0] diff_ff, diff_in;
   logic signed [34:0] prod_ff, prod_in;
   logic signed [34:0] acc_ff;
   logic [1:0]         dir_ff, dir_in;

   // result register
   logic               rsp_valid_ff;
   logic [1:0]         out_dir_ff;
   logic [7:0]         out_left_ff;
   logic [7:0]         out_right_ff;
   logic [15:0]        out_level_ff;
   logic signed [16:0] out_err_ff;

   logic signed [16:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [22:0] inc;
   logic signed [24:0] lvl_sum;
   logic signed [24:0] lvl_lo;
   logic signed [24:0] lvl_hi;
   logic signed [16:0] ang_ext;
   logic signed [16:0] db_pos;
   logic signed [16:0] db_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         kp_ff        <= RST_PROP_GAIN;
         kd_ff        <= RST_DERIV_GAIN;
         dead_band_ff <= '0;
         floor_ff     <= RST_DUTY_FLOOR;
         ceiling_ff   <= RST_DUTY_CEILING;
         scale_ff     <= RST_RIGHT_SCALE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_TARGET_ANGLE: target_ff    <= csr_wdata;
            CSR_PROP_GAIN:    kp_ff        <= csr_wdata;
            CSR_DERIV_GAIN:   kd_ff        <= csr_wdata;
            CSR_DEAD_BAND:    dead_band_ff <= csr_wdata[14:0];
            CSR_DUTY_FLOOR:   floor_ff     <= csr_wdata[7:0];
            CSR_DUTY_CEILING: ceiling_ff   <= csr_wdata[7:0];
            CSR_RIGHT_SCALE:  scale_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // error and its change
   assign err_in  = {target_ff[15], target_ff} - {req_tilt_angle[15], req_tilt_angle};
   assign diff_in = {err_ff[16], err_ff} - prev_ff;

   // dead band decision
   assign ang_ext = {angle_ff[15], angle_ff};
   assign db_pos  = {2'b00, dead_band_ff};
   assign db_neg  = -db_pos;

   always_comb begin
      if (ang_ext > db_pos) begin
         dir_in = DIR_BACKWARD;
      end else if (ang_ext < db_neg) begin
         dir_in = DIR_FORWARD;
      end else begin
         dir_in = DIR_STOPPED;
      end
   end

   // shared multiplier operand select
   always_comb begin
      priority if (cmd.diff) begin
         mul_a = {1'b0, kp_ff};
         mul_b = {err_ff[16], err_ff};
      end else if (cmd.muld) begin
         mul_a = {1'b0, kd_ff};
         mul_b = diff_ff;
      end else begin
         mul_a = {1'b0, scale_ff};
         mul_b = {2'b00, level_ff};
      end
   end
   assign prod_in = mul_a * mul_b;

   // floor division by 4096 is an arithmetic shift
   assign inc     = acc_ff[34:12];
   assign lvl_sum = {9'd0, level_ff} + {{2{inc[22]}}, inc};
   assign lvl_lo  = {9'd0, floor_ff, 8'd0};
   assign lvl_hi  = {9'd0, ceiling_ff, 8'd0};

   always_comb begin
      priority if (lvl_sum < lvl_lo) begin
         level_in = lvl_lo[15:0];
      end else if (lvl_sum > lvl_hi) begin
         level_in = lvl_hi[15:0];
      end else begin
         level_in = lvl_sum[15:0];
      end
   end

   // kept state
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= RST_DRIVE_LEVEL;
         prev_ff  <= '0;
      end else begin
         if (cmd.diff) begin
            prev_ff <= {err_ff[16], err_ff};
         end
         if (cmd.level) begin
            level_ff <= level_in;
         end
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         angle_ff <= req_tilt_angle;
         err_ff   <= err_in;
      end
      if (cmd.diff) begin
         diff_ff <= diff_in;
         dir_ff  <= dir_in;
      end
      if (cmd.diff || cmd.muld || cmd.scale) begin
         prod_ff <= prod_in;
      end
      if (cmd.muld) begin
         acc_ff <= prod_ff;
      end else if (cmd.sum) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_dir_ff   <= dir_ff;
         out_level_ff <= level_ff;
         out_err_ff   <= err_ff;
         if (dir_ff == DIR_STOPPED) begin
            out_left_ff  <= '0;
            out_right_ff <= '0;
         end else begin
            out_left_ff  <= level_ff[15:8];
            out_right_ff <= prod_ff[31:24];
         end
      end
   end

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_direction = out_dir_ff;
   assign rsp_left_duty       = out_left_ff;
   assign rsp_right_duty      = out_right_ff;
   assign rsp_drive_level_out = out_level_ff;
   assign rsp_angle_error     = out_err_ff;

endmodule

### rtl/core/pd_balance_motor_drive_unit.sv
// PD balance motor drive, top level. The sequencer walks each item through
// one shared 17x18 multiplier and takes a new item only after the last one
// has been loaded into the output register, which happens once the output is free.
// A result waiting in the output register does not block the next item.
// Reset (synchronous, active high): registers to defaults, drive level 55.0,
// last error 0, no result pending.
module pd_balance_motor_drive_unit (
   input  logic               clock,
   input  logic               reset,
   // configuration writes
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   // tilt samples in
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_tilt_angle,
   // motor commands out
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_drive_direction,
   output logic [7:0]         rsp_left_duty,
   output logic [7:0]         rsp_right_duty,
   output logic [15:0]        rsp_drive_level_out,
   output logic signed [16:0] rsp_angle_error
);
   import pdbal_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer: IDLE takes the item and forms the error, then the error
   // change and kp product, the kd product, their sum, the clamp and the
   // right duty product; DONE hands the item to the output register.
   pdbal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: holds config, drive level, last error and the result item.
   pdbal_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_tilt_angle      (req_tilt_angle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_direction (rsp_drive_direction),
      .rsp_left_duty       (rsp_left_duty),
      .rsp_right_duty      (rsp_right_duty),
      .rsp_drive_level_out (rsp_drive_level_out),
      .rsp_angle_error     (rsp_angle_error)
   );

endmodule

### sim/pd_balance_motor_drive_unit_test.sv
// Self-checking bench for pd_balance_motor_drive_unit: a directed table, then random tilt walks
// under changing gains, dead band and duty limits, each result checked against a PD predictor.
// Depends on pdbal_pkg (direction codes, register indexes, reset values) and the unit itself.
module pd_balance_motor_drive_unit_test;
   import pdbal_pkg::*;

   // No such register: a write here must change nothing
   localparam logic [2:0] CSR_NO_REG = 3'd7;
   localparam int ITEM_LATENCY = 7;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_PHASES = 9;
   localparam int ITEMS_PER_PHASE = 100;

   // One motor command as it leaves the unit
   typedef struct packed {
      logic [1:0]         dir;
      logic [7:0]         left;
      logic [7:0]         right;
      logic [15:0]        level;
      logic signed [16:0] err;
   } drive_cmd_type;

   // One line of the directed table: a register write or a tilt item,
   // the latter with a hand-typed command where it is obvious
   typedef struct packed {
      logic       is_write;
      logic [2:0] index;
      logic [15:0] value;
      logic       typed;
      drive_cmd_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_tilt_angle;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_drive_direction;
   logic [7:0]         rsp_left_duty;
   logic [7:0]         rsp_right_duty;
   logic [15:0]        rsp_drive_level_out;
   logic signed [16:0] rsp_angle_error;

   // Predictor copy of the settings
   logic signed [15:0] set_target;
   logic [15:0]        set_kp;
   logic [15:0]        set_kd;
   logic [14:0]        set_band;
   logic [7:0]         set_floor;
   logic [7:0]         set_ceiling;
   logic [15:0]        set_rscale;
   // Predictor copy of the controller state
   logic [15:0]        kept_level;
   logic signed [17:0] kept_error;

   drive_cmd_type due_cmds[$];
   stim_row_type  directed_rows[$];
   int         mismatches = 0;
   int         idle_cycles = 0;
   int         stall_left = 0;
   int         walk = 0;
   bit         calm = 1'b0;   // phase with no idling on either side

   pd_balance_motor_drive_unit uut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_tilt_angle(req_tilt_angle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_drive_direction(rsp_drive_direction),
      .rsp_left_duty(rsp_left_duty),
      .rsp_right_duty(rsp_right_duty),
      .rsp_drive_level_out(rsp_drive_level_out),
      .rsp_angle_error(rsp_angle_error)
   );

   always #5 clock = ~clock;

   task automatic reset_model();
      set_target  = '0;
      set_kp      = RST_PROP_GAIN;
      set_kd      = RST_DERIV_GAIN;
      set_band    = '0;
      set_floor   = RST_DUTY_FLOOR;
      set_ceiling = RST_DUTY_CEILING;
      set_rscale  = RST_RIGHT_SCALE;
      kept_level  = RST_DRIVE_LEVEL;
      kept_error  = '0;
   endtask

   // PD step: error, increment floored to Q8.8, clamp (floor test first),
   // direction against the dead band, duties, then the last error moves on
   function automatic drive_cmd_type next_drive_cmd(input logic signed [15:0] tilt);
      drive_cmd_type cmd;
      longint err, diff, kp, kd, pd_sum, lvl, lo, hi, band, prod;
      err    = longint'(set_target) - longint'(tilt);
      diff   = err - longint'(kept_error);
      kp     = longint'(set_kp);
      kd     = longint'(set_kd);
      pd_sum = kp * err + kd * diff;
      pd_sum = pd_sum >>> 12;   // floor, not truncation towards zero
      lvl    = longint'(kept_level) + pd_sum;
      lo     = longint'(set_floor) * 256;
      hi     = longint'(set_ceiling) * 256;
      if (lvl < lo) begin
         lvl = lo;
      end else if (lvl > hi) begin
         lvl = hi;
      end
      kept_level = lvl[15:0];
      band = longint'(set_band);
      if (longint'(tilt) > band) begin
         cmd.dir = DIR_BACKWARD;
      end else if (longint'(tilt) < -band) begin
         cmd.dir = DIR_FORWARD;
      end else begin
         cmd.dir = DIR_STOPPED;
      end
      prod = longint'(kept_level) * longint'(set_rscale);
      if (cmd.dir == DIR_STOPPED) begin
         cmd.left  = '0;
         cmd.right = '0;
      end else begin
         cmd.left  = kept_level[15:8];
         cmd.right = prod[31:24];
      end
      cmd.level  = kept_level;
      cmd.err    = err[16:0];
      kept_error = err[17:0];
      return cmd;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly a drifting tilt, some samples close around the dead band,
   // a few anywhere in the 16-bit range
   function automatic logic [15:0] pick_tilt();
      int r, band;
      logic [31:0] raw;
      r    = $urandom_range(0, 99);
      band = int'(set_band);
      raw  = $urandom;
      if (r < 10) return raw[15:0];
      if (r < 25) begin
         walk = int'(set_target) + int'($urandom_range(0, 2 * band + 2)) - band - 1;
      end else begin
         walk = walk + int'($urandom_range(0, 800)) - 400;
      end
      if (walk > 32767) walk = 32767;
      if (walk < -32768) walk = -32768;
      return walk[15:0];
   endfunction

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [16:0] got,
                              input logic [16:0] want);
      if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // Lower valid, let every command come out, then give the unit its latency
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (due_cmds.size() != 0) @(posedge clock);
      repeat (ITEM_LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_TARGET_ANGLE: set_target  = data;
         CSR_PROP_GAIN:    set_kp      = data;
         CSR_DERIV_GAIN:   set_kd      = data;
         CSR_DEAD_BAND:    set_band    = data[14:0];
         CSR_DUTY_FLOOR:   set_floor   = data[7:0];
         CSR_DUTY_CEILING: set_ceiling = data[7:0];
         CSR_RIGHT_SCALE:  set_rscale  = data;
         default: ;
      endcase
   endtask

   // Valid stays up across back-to-back items; it drops only for a gap or a drain
   task automatic send_tilt(input logic [15:0] tilt, input logic typed,
                            input drive_cmd_type want);
      int gap;
      drive_cmd_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_tilt_angle <= tilt;
      do @(posedge clock); while (!req_ready);
      predicted = next_drive_cmd(tilt);
      due_cmds.push_back(typed ? want : predicted);
   endtask

   function automatic void add_item(input int tilt);
      stim_row_type row;
      row       = '0;
      row.value = 16'(tilt);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_write(input logic [2:0] idx, input logic [15:0] data);
      stim_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.index    = idx;
      row.value    = data;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(input int tilt, input logic [1:0] dir, input int left,
                                     input int right, input int level, input int err);
      stim_row_type row;
      row            = '0;
      row.value      = 16'(tilt);
      row.typed      = 1'b1;
      row.want.dir   = dir;
      row.want.left  = 8'(left);
      row.want.right = 8'(right);
      row.want.level = 16'(level);
      row.want.err   = 17'(err);
      directed_rows.push_back(row);
   endfunction

   // Result side: ready with random stalls, none in a calm phase
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   // Result checker and watchdog
   always @(posedge clock) begin : check_results
      drive_cmd_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_cmds.size() == 0) begin
               flag_error("drive command with none expected");
            end else begin
               want = due_cmds.pop_front();
               check_field("drive_direction", 17'(rsp_drive_direction), 17'(want.dir));
               check_field("left_duty", 17'(rsp_left_duty), 17'(want.left));
               check_field("right_duty", 17'(rsp_right_duty), 17'(want.right));
               check_field("drive_level_out", 17'(rsp_drive_level_out), 17'(want.level));
               check_field("angle_error", rsp_angle_error, want.err);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase, n, r;
      logic [15:0] wd;
      int fl, cl;
      reset          <= 1'b1;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_TARGET_ANGLE;
      csr_wdata      <= '0;
      req_valid      <= 1'b0;
      req_tilt_angle <= '0;
      reset_model();

      // Out of reset: level 55.0, no error, zero dead band
      add_typed(0, DIR_STOPPED, 0, 0, 14080, 0);
      add_item(1);                   // just past the dead band
      add_item(-1);
      // full scale tilts pin the level to the floor, then to the ceiling
      add_typed(32767, DIR_BACKWARD, 55, 50, 14080, -32767);
      add_typed(-32768, DIR_FORWARD, 150, 138, 38400, 32768);
      // largest error both ways, and the largest error change
      add_write(CSR_TARGET_ANGLE, 16'h7FFF);
      add_item(-32768);
      add_write(CSR_TARGET_ANGLE, 16'h8000);
      add_item(32767);
      // zero gains hold the level, full gains swing it
      add_write(CSR_TARGET_ANGLE, 16'h0000);
      add_write(CSR_PROP_GAIN, 16'h0000);
      add_write(CSR_DERIV_GAIN, 16'h0000);
      add_item(5000);
      add_write(CSR_PROP_GAIN, 16'hFFFF);
      add_write(CSR_DERIV_GAIN, 16'hFFFF);
      add_item(-20000);
      add_item(20000);
      // dead band edges: equal to the band stops, one past it drives
      add_write(CSR_DEAD_BAND, 16'd100);
      add_item(100);
      add_item(101);
      add_item(-100);
      add_item(-101);
      // bit 15 of the dead band is dropped: band becomes the widest
      add_write(CSR_DEAD_BAND, 16'hFFFF);
      add_item(32767);
      add_item(-32768);
      // floor above ceiling
      add_write(CSR_DEAD_BAND, 16'd0);
      add_write(CSR_DUTY_FLOOR, 16'd200);
      add_write(CSR_DUTY_CEILING, 16'd100);
      add_item(-300);
      add_item(300);
      // zero limits, with junk in the upper byte of the floor
      add_write(CSR_DUTY_FLOOR, 16'hFF00);
      add_write(CSR_DUTY_CEILING, 16'd0);
      add_typed(-500, DIR_FORWARD, 0, 0, 0, 500);
      // top limits, full and zero right scale
      add_write(CSR_DUTY_FLOOR, 16'd255);
      add_write(CSR_DUTY_CEILING, 16'd255);
      add_write(CSR_RIGHT_SCALE, 16'hFFFF);
      add_typed(-7, DIR_FORWARD, 255, 254, 65280, 7);
      add_write(CSR_RIGHT_SCALE, 16'd0);
      add_typed(9, DIR_BACKWARD, 255, 0, 65280, -9);
      // write to an index past the register list
      add_write(CSR_NO_REG, 16'hFFFF);
      add_typed(0, DIR_STOPPED, 0, 0, 65280, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            write_reg(directed_rows[i].index, directed_rows[i].value);
         end else begin
            send_tilt(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases; the first one goes back to the reset settings
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         calm = (phase % 3 == 2);
         if (phase == 0) begin
            write_reg(CSR_TARGET_ANGLE, 16'd0);
            write_reg(CSR_PROP_GAIN, RST_PROP_GAIN);
            write_reg(CSR_DERIV_GAIN, RST_DERIV_GAIN);
            write_reg(CSR_DEAD_BAND, 16'd0);
            write_reg(CSR_DUTY_FLOOR, 16'(RST_DUTY_FLOOR));
            write_reg(CSR_DUTY_CEILING, 16'(RST_DUTY_CEILING));
            write_reg(CSR_RIGHT_SCALE, RST_RIGHT_SCALE);
         end else begin
            r = $urandom_range(0, 99);
            wd = 16'($urandom_range(0, 4096) - 2048);
            if (r < 10) wd = 16'h8000;
            else if (r < 20) wd = 16'h7FFF;
            write_reg(CSR_TARGET_ANGLE, wd);

            r = $urandom_range(0, 99);
            wd = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : 16'($urandom_range(256, 16384));
            write_reg(CSR_PROP_GAIN, wd);
            r = $urandom_range(0, 99);
            wd = (r < 15) ? 16'd0 : (r < 30) ? 16'hFFFF : 16'($urandom_range(256, 16384));
            write_reg(CSR_DERIV_GAIN, wd);

            wd = 16'($urandom);   // top bit is random and ignored
            wd[14:0] = ($urandom_range(0, 9) == 0) ? 15'h7FFF : 15'($urandom_range(0, 1024));
            write_reg(CSR_DEAD_BAND, wd);

            r = $urandom_range(0, 99);
            if (r < 70) begin
               fl = $urandom_range(0, 120);
               cl = $urandom_range(fl, 255);
            end else if (r < 85) begin
               fl = $urandom_range(100, 255);
               cl = $urandom_range(0, fl);
            end else begin
               fl = $urandom_range(0, 1) * 255;
               cl = $urandom_range(0, 1) * 255;
            end
            wd = 16'($urandom);   // upper byte is random and ignored
            wd[7:0] = 8'(fl);
            write_reg(CSR_DUTY_FLOOR, wd);
            wd = 16'($urandom);
            wd[7:0] = 8'(cl);
            write_reg(CSR_DUTY_CEILING, wd);

            r = $urandom_range(0, 99);
            wd = 16'($urandom);
            if (r < 15) wd = 16'd0;
            else if (r < 30) wd = 16'hFFFF;
            write_reg(CSR_RIGHT_SCALE, wd);
            write_reg(CSR_NO_REG, 16'($urandom));
         end
         walk = int'(set_target);
         for (n = 0; n < ITEMS_PER_PHASE; n++) send_tilt(pick_tilt(), 1'b0, '0);
      end

      wait_drained();
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
